>>> rtl/core/rcr_pkg.sv
// Shared constants, codes and types of the rectangle canvas rasterizer.
package rcr_pkg;

    localparam int MAX_SIDE   = 256;
    localparam int FRAC_BITS  = 8;

    localparam int FIELD_W    = 24;
    localparam int CHAR_W     = 8;
    localparam int CFG_W      = 9;
    localparam int RC_W       = 8;
    localparam int STATUS_W   = 2;
    localparam int OPCODE_W   = 2;

    localparam int SIDE_W     = $clog2(MAX_SIDE);
    localparam int CNT_W      = SIDE_W + 1;
    localparam int LIM_W      = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int ADDR_W     = 2 * SIDE_W;
    localparam int MEM_DEPTH  = MAX_SIDE * MAX_SIDE;

    localparam int CW_A       = FIELD_W + 2;
    localparam int CW_B       = SIDE_W + FRAC_BITS + 2;
    localparam int CW         = (CW_A > CW_B) ? CW_A : CW_B;
    localparam logic signed [CW-1:0] FIX_ONE = CW'(64'd1 << FRAC_BITS);

    localparam int S_DATA_W   = 4 * FIELD_W + CHAR_W + 2 * RC_W;
    localparam int S_USER_W   = OPCODE_W + 1;
    localparam int M_DATA_W   = ((CHAR_W + STATUS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

    localparam logic [CHAR_W-1:0] BG_RESET = 8'd32;

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        K_CLEAR,
        K_DRAW,
        K_READ,
        K_REPORT
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [STATUS_W-1:0]  status;
        logic                 filled;
        logic [CHAR_W-1:0]    paint;
        logic [SIDE_W-1:0]    row;
        logic [SIDE_W-1:0]    col;
        logic signed [CW-1:0] x_lo;
        logic signed [CW-1:0] x_lo1;
        logic signed [CW-1:0] x_hi1;
        logic signed [CW-1:0] x_hi;
        logic signed [CW-1:0] y_lo;
        logic signed [CW-1:0] y_lo1;
        logic signed [CW-1:0] y_hi1;
        logic signed [CW-1:0] y_hi;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]  wd;
        logic [CNT_W-1:0]  ht;
        logic [CHAR_W-1:0] bg;
    } t_cfg;

    typedef struct packed {
        logic push;
        logic full;
    } t_qctl;

endpackage

>>> rtl/core/rcr_front.sv
// Front end: configuration registers, item intake and command classification.
module rcr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [rcr_pkg::S_DATA_W-1:0]  i_s_tdata,
    input  logic [rcr_pkg::S_USER_W-1:0]  i_s_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_push,
    output rcr_pkg::t_cmd                 o_cmd,
    output rcr_pkg::t_cfg                 o_cfg
);
    import rcr_pkg::*;

    logic [CFG_W-1:0]  r_cfg_w;
    logic [CFG_W-1:0]  r_cfg_h;
    logic [CHAR_W-1:0] r_bg;

    logic [LIM_W-1:0]  wd_ext;
    logic [LIM_W-1:0]  ht_ext;
    logic [LIM_W-1:0]  wd_lim;
    logic [LIM_W-1:0]  ht_lim;

    logic [OPCODE_W-1:0]       opcode;
    logic                      filled;
    logic signed [FIELD_W-1:0] rect_x;
    logic signed [FIELD_W-1:0] rect_y;
    logic signed [FIELD_W-1:0] rect_w;
    logic signed [FIELD_W-1:0] rect_h;
    logic [CHAR_W-1:0]         paint_char;
    logic [RC_W-1:0]           read_row;
    logic [RC_W-1:0]           read_col;
    logic signed [CW-1:0]      x_ext;
    logic signed [CW-1:0]      y_ext;
    logic signed [CW-1:0]      w_ext;
    logic signed [CW-1:0]      h_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= '0;
            r_cfg_h <= '0;
            r_bg    <= BG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WIDTH:  r_cfg_w <= i_cfg_data;
                REG_HEIGHT: r_cfg_h <= i_cfg_data;
                REG_BG:     r_bg    <= i_cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign wd_ext = LIM_W'(r_cfg_w);
    assign ht_ext = LIM_W'(r_cfg_h);
    assign wd_lim = (wd_ext > LIM_W'(MAX_SIDE)) ? LIM_W'(MAX_SIDE) : wd_ext;
    assign ht_lim = (ht_ext > LIM_W'(MAX_SIDE)) ? LIM_W'(MAX_SIDE) : ht_ext;

    assign o_cfg.wd = CNT_W'(wd_lim);
    assign o_cfg.ht = CNT_W'(ht_lim);
    assign o_cfg.bg = r_bg;

    assign opcode     = i_s_tuser[1:0];
    assign filled     = i_s_tuser[2];
    assign rect_x     = i_s_tdata[23:0];
    assign rect_y     = i_s_tdata[47:24];
    assign rect_w     = i_s_tdata[71:48];
    assign rect_h     = i_s_tdata[95:72];
    assign paint_char = i_s_tdata[103:96];
    assign read_row   = i_s_tdata[111:104];
    assign read_col   = i_s_tdata[119:112];

    assign x_ext = CW'(rect_x);
    assign y_ext = CW'(rect_y);
    assign w_ext = CW'(rect_w);
    assign h_ext = CW'(rect_h);

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    always_comb begin
        o_cmd        = '0;
        o_cmd.filled = filled;
        o_cmd.paint  = paint_char;
        o_cmd.row    = SIDE_W'(read_row);
        o_cmd.col    = SIDE_W'(read_col);
        o_cmd.x_lo   = x_ext;
        o_cmd.x_lo1  = x_ext + FIX_ONE;
        o_cmd.x_hi   = x_ext + w_ext;
        o_cmd.x_hi1  = x_ext + w_ext - FIX_ONE;
        o_cmd.y_lo   = y_ext;
        o_cmd.y_lo1  = y_ext + FIX_ONE;
        o_cmd.y_hi   = y_ext + h_ext;
        o_cmd.y_hi1  = y_ext + h_ext - FIX_ONE;
        o_cmd.status = ST_DONE;
        case (opcode)
            OP_CLEAR: o_cmd.kind = K_CLEAR;
            OP_DRAW: begin
                if (rect_w <= 0 || rect_h <= 0) begin
                    o_cmd.kind   = K_REPORT;
                    o_cmd.status = ST_REJECT;
                end else begin
                    o_cmd.kind = K_DRAW;
                end
            end
            OP_READ: begin
                if (LIM_W'(read_row) >= ht_lim || LIM_W'(read_col) >= wd_lim) begin
                    o_cmd.kind   = K_REPORT;
                    o_cmd.status = ST_OUTSIDE;
                end else begin
                    o_cmd.kind = K_READ;
                end
            end
            default: o_cmd.kind = K_REPORT;
        endcase
    end

endmodule

>>> rtl/core/rcr_cmd_fifo.sv
// Short command queue between the front end and the canvas engine.
module rcr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rcr_pkg::t_qctl i_ctl,
    input  rcr_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output rcr_pkg::t_cmd o_cmd
);
    import rcr_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_ctl.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/rcr_engine.sv
// Canvas engine: cell memory, clear and draw sweeps, reads and the result register.
module rcr_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rcr_pkg::t_cfg                i_cfg,
    input  logic                         i_q_valid,
    input  rcr_pkg::t_cmd                i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [rcr_pkg::M_DATA_W-1:0] o_m_tdata
);
    import rcr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_READ,
        S_DONE
    } t_state;

    t_state            r_state,      n_state;
    t_cmd              r_cmd,        n_cmd;
    logic [SIDE_W-1:0] r_row,        n_row;
    logic [SIDE_W-1:0] r_col,        n_col;
    logic [CNT_W-1:0]  r_lim_w,      n_lim_w;
    logic [CNT_W-1:0]  r_lim_h,      n_lim_h;
    logic              r_out_valid,  n_out_valid;
    logic [CHAR_W-1:0] r_out_char,   n_out_char;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic [CHAR_W-1:0] r_cells [MEM_DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    logic              out_free;
    logic              last_col;
    logic              last_row;
    logic [ADDR_W-1:0] addr;
    logic              we;
    logic [CHAR_W-1:0] wdata;
    logic [CW-1:0]     px_u;
    logic [CW-1:0]     py_u;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic              in_rect;
    logic              border;
    logic              paint;

    assign out_free = !r_out_valid || i_m_tready;
    assign last_col = (CNT_W'(r_col) + 1'b1) == r_lim_w;
    assign last_row = (CNT_W'(r_row) + 1'b1) == r_lim_h;
    assign addr     = {r_row, r_col};

    assign px_u = CW'(r_col) << FRAC_BITS;
    assign py_u = CW'(r_row) << FRAC_BITS;
    assign px   = signed'(px_u);
    assign py   = signed'(py_u);

    assign in_rect = (px >= r_cmd.x_lo) && (px <= r_cmd.x_hi) &&
                     (py >= r_cmd.y_lo) && (py <= r_cmd.y_hi);
    assign border = (px < r_cmd.x_lo1) || (px > r_cmd.x_hi1) ||
                    (py < r_cmd.y_lo1) || (py > r_cmd.y_hi1);
    assign paint  = in_rect && (r_cmd.filled || border);

    assign we    = (r_state == S_SWEEP) && ((r_cmd.kind == K_CLEAR) || paint);
    assign wdata = (r_cmd.kind == K_CLEAR) ? i_cfg.bg : r_cmd.paint;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_cells[addr] <= wdata;
        end
        r_rd_data <= r_cells[addr];
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_row        = r_row;
        n_col        = r_col;
        n_lim_w      = r_lim_w;
        n_lim_h      = r_lim_h;
        n_out_valid  = r_out_valid;
        n_out_char   = r_out_char;
        n_out_status = r_out_status;
        o_q_pop      = 1'b0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.kind)
                        K_REPORT: begin
                            if (out_free) begin
                                o_q_pop      = 1'b1;
                                n_out_valid  = 1'b1;
                                n_out_char   = '0;
                                n_out_status = i_q_cmd.status;
                            end
                        end
                        K_READ: begin
                            o_q_pop = 1'b1;
                            n_cmd   = i_q_cmd;
                            n_row   = i_q_cmd.row;
                            n_col   = i_q_cmd.col;
                            n_state = S_READ;
                        end
                        K_CLEAR: begin
                            o_q_pop = 1'b1;
                            n_cmd   = i_q_cmd;
                            n_row   = '0;
                            n_col   = '0;
                            n_lim_w = CNT_W'(MAX_SIDE);
                            n_lim_h = CNT_W'(MAX_SIDE);
                            n_state = S_SWEEP;
                        end
                        K_DRAW: begin
                            o_q_pop = 1'b1;
                            n_cmd   = i_q_cmd;
                            n_row   = '0;
                            n_col   = '0;
                            n_lim_w = i_cfg.wd;
                            n_lim_h = i_cfg.ht;
                            n_state = (i_cfg.wd == '0 || i_cfg.ht == '0) ? S_DONE : S_SWEEP;
                        end
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                if (last_col) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                    if (last_row) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_READ: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = (r_cmd.kind == K_READ) ? r_rd_data : '0;
                    n_out_status = r_cmd.status;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_row        <= n_row;
        r_col        <= n_col;
        r_lim_w      <= n_lim_w;
        r_lim_h      <= n_lim_h;
        r_out_char   <= n_out_char;
        r_out_status <= n_out_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'({r_out_status, r_out_char});

endmodule

>>> rtl/core/rectangle_canvas_rasterizer.sv
// Top level of the rectangle canvas rasterizer: front end, command queue and canvas engine.
//
//  channel | direction | handshake                | content
//  --------+-----------+--------------------------+-------------------------------------------
//  s       | in        | i_s_tvalid / o_s_tready  | command item: opcode, mode, rectangle, cell
//  m       | out       | o_m_tvalid / i_m_tready  | result item: cell_char, status
//  cfg     | in        | i_cfg_valid / o_cfg_ready| register index and value
//
//  Clear sweeps all MAX_SIDE*MAX_SIDE cells, draw sweeps width*height cells (none for an
//  empty canvas), reads and rejected or out-of-canvas items none; the single write port
//  of the cell memory, one cell per cycle, sets the sweep length.
//  Reset clears control state only; canvas cells are undefined until the first clear.
//  A two-entry command queue takes items while the engine sweeps until it is full; the result
//  register holds while the output side stalls.
module rectangle_canvas_rasterizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // rect_x[23:0], rect_y[47:24], rect_w[71:48], rect_h[95:72],
    // paint_char[103:96], read_row[111:104], read_col[119:112]
    input  logic [rcr_pkg::S_DATA_W-1:0]  i_s_tdata,
    // opcode[1:0], filled[2]
    input  logic [rcr_pkg::S_USER_W-1:0]  i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // cell_char[7:0], status[9:8], zero[15:10]
    output logic [rcr_pkg::M_DATA_W-1:0]  o_m_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcr_pkg::CFG_W-1:0]     i_cfg_data
);
    import rcr_pkg::*;

    t_cmd  front_cmd;
    t_cmd  q_cmd;
    t_cfg  cfg;
    t_qctl qctl;
    logic  q_valid;
    logic  q_pop;
    logic  q_full;
    logic  push;

    assign qctl.push = push;
    assign qctl.full = q_full;

    rcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (qctl.full),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .o_cfg       (cfg)
    );

    rcr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    rcr_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

>>> rtl/core/rcr_checker.sv
// Port-level checks of the rectangle canvas rasterizer and their binding.
module rcr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [rcr_pkg::M_DATA_W-1:0]  o_m_tdata
);
    import rcr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[9:8] == ST_DONE || o_m_tdata[9:8] == ST_REJECT ||
                        o_m_tdata[9:8] == ST_OUTSIDE))
        else $error("unknown status code");

    a_error_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[9:8] != ST_DONE |-> o_m_tdata[7:0] == '0 &&
                                                   o_m_tdata[M_DATA_W-1:10] == '0)
        else $error("error result carries a character");

endmodule

bind rectangle_canvas_rasterizer rcr_checker u_rcr_checker (.*);

>>> verif/tb.sv
// Self-checking testbench for the rectangle canvas rasterizer stream block.
module tb;
    import rcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;
    localparam logic [CHAR_W-1:0] CH_FILL = 8'h52;
    localparam logic [CHAR_W-1:0] CH_EDGE = 8'h72;

    typedef struct {
        logic [OPCODE_W-1:0]       opcode;
        logic                      filled;
        logic signed [FIELD_W-1:0] rect_x;
        logic signed [FIELD_W-1:0] rect_y;
        logic signed [FIELD_W-1:0] rect_w;
        logic signed [FIELD_W-1:0] rect_h;
        logic [CHAR_W-1:0]         paint_char;
        logic [RC_W-1:0]           read_row;
        logic [RC_W-1:0]           read_col;
    } t_tb_cmd;

    typedef struct {
        logic [CHAR_W-1:0]   cell_char;
        logic [STATUS_W-1:0] status;
    } t_cell_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata = '0;
    logic [S_USER_W-1:0]   i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    rectangle_canvas_rasterizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic [CHAR_W-1:0] canvas_copy [MAX_SIDE*MAX_SIDE];
    int unsigned       cols_cfg = 0;
    int unsigned       rows_cfg = 0;
    logic [CHAR_W-1:0] bg_cfg = BG_RESET;

    t_tb_cmd      cmd_pending [$];
    t_cell_result cells_due [$];
    t_tb_cmd      cmd_on_bus;
    t_tb_cmd      cmd_next;
    t_cell_result cell_due;
    int           src_gap = 0;
    int           snk_gap = 0;
    bit           idling_on = 1'b1;
    int           clears_left = 2;
    int           errors = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("rectangle_canvas_rasterizer: mismatch");
        $finish;
    end

    function automatic int unsigned clamp_side(int unsigned v);
        return (v > MAX_SIDE) ? MAX_SIDE : v;
    endfunction

    function automatic t_cell_result rasterize_command(t_tb_cmd c);
        t_cell_result res;
        int unsigned  wd;
        int unsigned  ht;
        longint       x, y, w, h, right, bottom, px, py;
        bit           in_rect, on_border;
        res.cell_char = '0;
        res.status    = ST_DONE;
        wd = clamp_side(cols_cfg);
        ht = clamp_side(rows_cfg);
        case (c.opcode)
            OP_CLEAR: begin
                foreach (canvas_copy[i]) canvas_copy[i] = bg_cfg;
            end
            OP_DRAW: begin
                x = longint'(c.rect_x);
                y = longint'(c.rect_y);
                w = longint'(c.rect_w);
                h = longint'(c.rect_h);
                right  = x + w;
                bottom = y + h;
                if (w <= 0 || h <= 0) begin
                    res.status = ST_REJECT;
                end else begin
                    for (int r = 0; r < ht; r++) begin
                        for (int col = 0; col < wd; col++) begin
                            px = longint'(col) <<< FRAC_BITS;
                            py = longint'(r) <<< FRAC_BITS;
                            in_rect = !(px < x || px > right || py < y || py > bottom);
                            on_border = in_rect && (px - x < (1 <<< FRAC_BITS) ||
                                        right - px < (1 <<< FRAC_BITS) ||
                                        py - y < (1 <<< FRAC_BITS) ||
                                        bottom - py < (1 <<< FRAC_BITS));
                            if ((c.filled && in_rect) || (!c.filled && on_border))
                                canvas_copy[r*MAX_SIDE + col] = c.paint_char;
                        end
                    end
                end
            end
            OP_READ: begin
                if (c.read_row >= ht || c.read_col >= wd)
                    res.status = ST_OUTSIDE;
                else
                    res.cell_char = canvas_copy[int'(c.read_row)*MAX_SIDE + int'(c.read_col)];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_tb_cmd make_cmd(logic [OPCODE_W-1:0] op, logic fill,
                                         logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                         logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] h,
                                         logic [CHAR_W-1:0] pc, logic [RC_W-1:0] row,
                                         logic [RC_W-1:0] col);
        t_tb_cmd c;
        c.opcode = op;
        c.filled = fill;
        c.rect_x = x;
        c.rect_y = y;
        c.rect_w = w;
        c.rect_h = h;
        c.paint_char = pc;
        c.read_row = row;
        c.read_col = col;
        return c;
    endfunction

    function automatic t_tb_cmd random_cmd();
        t_tb_cmd     c;
        int unsigned wd;
        int unsigned ht;
        int unsigned p;
        wd = clamp_side(cols_cfg);
        ht = clamp_side(rows_cfg);
        c = make_cmd(OPCODE_W'($urandom), 1'($urandom), FIELD_W'($urandom),
                     FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                     CHAR_W'($urandom), RC_W'($urandom), RC_W'($urandom));
        p = $urandom_range(0, 99);
        if (p < 3 && clears_left > 0) begin
            clears_left--;
            c.opcode = OP_CLEAR;
        end else if (p < 50) begin
            c.opcode = OP_DRAW;
            if ($urandom_range(0, 99) < 85) begin
                c.rect_x = FIELD_W'(int'($urandom_range(0, (wd + 4) * 256)) - 512);
                c.rect_y = FIELD_W'(int'($urandom_range(0, (ht + 4) * 256)) - 512);
                c.rect_w = FIELD_W'($urandom_range(1, (wd + 2) * 256));
                c.rect_h = FIELD_W'($urandom_range(1, (ht + 2) * 256));
                if ($urandom_range(0, 1)) begin
                    c.rect_x[7:0] = '0;
                    c.rect_y[7:0] = '0;
                    c.rect_w[7:0] = '0;
                    c.rect_h[7:0] = '0;
                end
                if ($urandom_range(0, 99) < 8) begin
                    if ($urandom_range(0, 1))
                        c.rect_w = FIELD_W'(-int'($urandom_range(0, 300)));
                    else
                        c.rect_h = FIELD_W'(-int'($urandom_range(0, 300)));
                end
            end
        end else if (p < 95) begin
            c.opcode = OP_READ;
            if ($urandom_range(0, 99) < 85 && wd > 0 && ht > 0) begin
                c.read_row = RC_W'($urandom_range(0, ht - 1));
                c.read_col = RC_W'($urandom_range(0, wd - 1));
            end
        end else begin
            c.opcode = OP_NOP;
        end
        return c;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_WIDTH:  cols_cfg = 32'(val);
            REG_HEIGHT: rows_cfg = 32'(val);
            REG_BG:     bg_cfg = val[CHAR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_pending.size() != 0 || i_s_tvalid || cells_due.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic queue_random(int n);
        @(negedge i_clk);
        repeat (n) cmd_pending.push_back(random_cmd());
    endtask

    // source side: hold the item until accepted, idle in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (src_gap > 0) begin
                src_gap    <= src_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                src_gap    <= $urandom_range(0, 17);
                i_s_tvalid <= 1'b0;
            end else if (cmd_pending.size() > 0) begin
                cmd_next = cmd_pending.pop_front();
                i_s_tdata <= {cmd_next.read_col, cmd_next.read_row, cmd_next.paint_char,
                              cmd_next.rect_h, cmd_next.rect_w, cmd_next.rect_y,
                              cmd_next.rect_x};
                i_s_tuser  <= {cmd_next.filled, cmd_next.opcode};
                cmd_on_bus <= cmd_next;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result side: stall in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap    <= snk_gap - 1;
            i_m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            snk_gap    <= $urandom_range(0, 17);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (cells_due.size() == 0) begin
                $error("result item with none pending: tdata %h", o_m_tdata);
                errors++;
            end else begin
                cell_due = cells_due.pop_front();
                if (o_m_tdata[CHAR_W-1:0] !== cell_due.cell_char) begin
                    $error("cell_char: expected %0d, got %0d", cell_due.cell_char,
                           o_m_tdata[CHAR_W-1:0]);
                    errors++;
                end
                if (o_m_tdata[CHAR_W +: STATUS_W] !== cell_due.status) begin
                    $error("status: expected %0d, got %0d", cell_due.status,
                           o_m_tdata[CHAR_W +: STATUS_W]);
                    errors++;
                end
                if (o_m_tdata[M_DATA_W-1:CHAR_W+STATUS_W] !== '0) begin
                    $error("tdata padding: expected 0, got %0h",
                           o_m_tdata[M_DATA_W-1:CHAR_W+STATUS_W]);
                    errors++;
                end
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready)
            cells_due.push_back(rasterize_command(cmd_on_bus));
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty canvas: every read is outside, draws touch nothing
        @(negedge i_clk);
        cmd_pending.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8'd0, 8'd0));
        cmd_pending.push_back(make_cmd(OP_READ, 1, '1, '1, '1, '1, '1, 8'd255, 8'd255));
        cmd_pending.push_back(make_cmd(OP_NOP, 1, 24'h000100, 0, 24'h000100, 24'h000100,
                                       8'hAA, 8'h55, 8'hAA));
        cmd_pending.push_back(make_cmd(OP_DRAW, 1, 0, 0, 24'h000000, 24'h000100,
                                       8'h41, 0, 0));
        cmd_pending.push_back(make_cmd(OP_DRAW, 0, 0, 0, 24'h000100, 24'hFFFFFF,
                                       8'h41, 0, 0));
        cmd_pending.push_back(make_cmd(OP_DRAW, 1, 0, 0, 24'h800000, 24'h7FFFFF,
                                       8'h41, 0, 0));
        cmd_pending.push_back(make_cmd(OP_DRAW, 1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                                       24'h7FFFFF, 8'hFF, 0, 0));
        cmd_pending.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_idle();

        // full canvas, width past the maximum side
        write_reg(REG_WIDTH, 9'd511);
        write_reg(REG_HEIGHT, 9'd256);
        write_reg(REG_BG, 9'd0);
        @(negedge i_clk);
        cmd_pending.push_back(make_cmd(OP_DRAW, 1, 24'hFFFF00, 24'hFFFF00, 24'h7FFFFF,
                                       24'h7FFFFF, CH_FILL, 0, 0));
        cmd_pending.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8'd255, 8'd255));
        cmd_pending.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8'd0, 8'd0));
        cmd_pending.push_back(make_cmd(OP_DRAW, 0, 0, 0, 24'h00FF00, 24'h00FF00,
                                       CH_EDGE, 0, 0));
        cmd_pending.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8'd0, 8'd0));
        cmd_pending.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8'd128, 8'd128));
        cmd_pending.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8'd255, 8'd0));
        cmd_pending.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8'd254, 8'd254));
        cmd_pending.push_back(make_cmd(OP_CLEAR, 1, 0, 0, 0, 0, 8'hFF, 0, 0));
        cmd_pending.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8'd200, 8'd17));
        wait_idle();

        // small canvas, fractional edges, then random traffic
        write_reg(REG_WIDTH, 9'd16);
        write_reg(REG_HEIGHT, 9'd12);
        write_reg(REG_BG, 9'd255);
        @(negedge i_clk);
        cmd_pending.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(OP_DRAW, 1, 24'h000180, 24'h000080, 24'h000200,
                                       24'h000040, 8'h23, 0, 0));
        cmd_pending.push_back(make_cmd(OP_DRAW, 0, 24'h000180, 24'h000080, 24'h000200,
                                       24'h000300, 8'h2B, 0, 0));
        cmd_pending.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8'd1, 8'd2));
        cmd_pending.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 8'd12, 8'd3));
        queue_random(45);
        wait_idle();

        write_reg(REG_WIDTH, 9'd1);
        write_reg(REG_HEIGHT, 9'd256);
        write_reg(REG_BG, 9'($urandom_range(0, 255)));
        queue_random(25);
        wait_idle();

        write_reg(REG_WIDTH, 9'($urandom_range(2, 20)));
        write_reg(REG_HEIGHT, 9'($urandom_range(2, 20)));
        write_reg(REG_BG, 9'($urandom_range(0, 255)));
        idling_on = 1'b0;
        queue_random(30);
        wait_idle();

        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("rectangle_canvas_rasterizer: match");
        end else begin
            $display("rectangle_canvas_rasterizer: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/rcr_pkg.sv
rtl/core/rcr_front.sv
rtl/core/rcr_cmd_fifo.sv
rtl/core/rcr_engine.sv
rtl/core/rectangle_canvas_rasterizer.sv
rtl/core/rcr_checker.sv
verif/tb.sv
